@@ rtl/cwct_pkg.sv @@
package cwct_pkg;

	// Root search: one time bit per stage, 17 bits cover times up to 131071.
	localparam int SRCH_STEPS = 17;
	// Width of the quadratic test value a*T^2 + 2^17*h*T + 2^32*c.
	localparam int FW = 112;
	// Width of the running product a*T.
	localparam int GW = 81;
	// Quotient bits produced by the divider below the overflow check.
	localparam int QW = 31;
	localparam int DIV_LAT = QW + 1;

	localparam logic [1:0] REG_CENTER_X     = 2'd0;
	localparam logic [1:0] REG_CENTER_Y     = 2'd1;
	localparam logic [1:0] REG_ARENA_RADIUS = 2'd2;
	localparam logic [1:0] REG_EPSILON      = 2'd3;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic [16:0]        tnow;
		logic signed [17:0] last;
	} carry_t;

	typedef struct packed {
		logic               vld;
		logic               srch;
		logic               t_zero;
		logic signed [18:0] lim;
		logic [63:0]        a;
		logic signed [65:0] h;
		logic signed [FW-1:0] f;
		logic [GW-1:0]      g;
		logic [16:0]        t0;
		carry_t             cy;
	} srch_t;

	typedef struct packed {
		logic        hit;
		logic [17:0] tf;
		logic        ngx;
		logic        ngy;
		logic        qz;
	} sb_t;

endpackage

@@ rtl/cwct_srch_stage.sv @@
module cwct_srch_stage #(
	parameter int BIT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cwct_pkg::srch_t d,
	output cwct_pkg::srch_t q
);

	localparam int FW = cwct_pkg::FW;
	localparam int GW = cwct_pkg::GW;

	logic signed [FW-1:0] g_w;
	logic signed [FW-1:0] a_w;
	logic signed [FW-1:0] h_w;
	logic signed [FW-1:0] cand;
	logic                 take;
	cwct_pkg::srch_t      nxt;
	cwct_pkg::srch_t      pay_s1;
	logic                 vld_s1;

	// f(T + 2^BIT) = f(T) + 2^(BIT+1)*a*T + 2^(2*BIT)*a + 2^(17+BIT)*h.
	// The time bit is kept while the test value stays negative, so the stages
	// end on the largest time before the wall is reached.
	always_comb begin
		g_w  = $signed({{(FW-GW){1'b0}}, d.g}) <<< (BIT + 1);
		a_w  = $signed({{(FW-64){1'b0}}, d.a}) <<< (2 * BIT);
		h_w  = $signed({{(FW-66){d.h[65]}}, d.h}) <<< (17 + BIT);
		cand = d.f + g_w + a_w + h_w;
		take = d.srch && cand[FW-1];
		nxt  = d;
		if (take) begin
			nxt.f  = cand;
			nxt.g  = d.g + (GW'(d.a) << BIT);
			nxt.t0 = d.t0 | (17'd1 << BIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		pay_s1 <= nxt;
	end

	always_comb begin
		q     = pay_s1;
		q.vld = vld_s1;
	end

endmodule

@@ rtl/cwct_div.sv @@
module cwct_div (
	input  logic                     clk,
	input  logic [63:0]              num,
	input  logic [31:0]              den,
	output logic                     ovf,
	output logic [cwct_pkg::QW-1:0]  quo
);

	localparam int QW = cwct_pkg::QW;

	logic [62:0]   rem_s [0:QW];
	logic [31:0]   den_s [0:QW];
	logic [QW-1:0] quo_s [0:QW];
	logic          ovf_s [0:QW];

	// A quotient of 2^31 or more saturates either way, so it is flagged up
	// front and the remaining bits come one per stage.
	always_ff @(posedge clk) begin
		ovf_s[0] <= num >= {1'b0, den, 31'b0};
		rem_s[0] <= num[62:0];
		den_s[0] <= den;
		quo_s[0] <= '0;
	end

	for (genvar i = 1; i <= QW; i++) begin : g_bit
		logic [62:0] sub;
		logic        ge;

		always_comb begin
			sub = 63'(den_s[i-1]) << (QW - i);
			ge  = rem_s[i-1] >= sub;
		end

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? rem_s[i-1] - sub : rem_s[i-1];
			quo_s[i] <= ge ? quo_s[i-1] | (QW'(1) << (QW - i)) : quo_s[i-1];
			den_s[i] <= den_s[i-1];
			ovf_s[i] <= ovf_s[i-1];
		end
	end

	assign ovf = ovf_s[QW];
	assign quo = quo_s[QW];

endmodule

@@ rtl/circular_wall_collision_time_unit.sv @@
// Wall collision time of a disc inside a circular arena. One disc is taken
// in every clock cycle (busy never rises) and its result leaves on a
// one-cycle result_valid strobe that cannot be held off. The pipeline
// holds the 17-stage root search, one time bit per stage, and the two
// 32-stage dividers that form the reflection velocity change.
// Configuration is always ready and should only be written while no disc
// is in flight.
module circular_wall_collision_time_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic [30:0]        disc_radius,
	input  logic [16:0]        time_now,
	input  logic signed [17:0] last_wall_time,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               result_valid,
	output logic               hit,
	output logic [17:0]        hit_time,
	output logic signed [31:0] dv_x,
	output logic signed [31:0] dv_y
);

	localparam int SRCH_STEPS = cwct_pkg::SRCH_STEPS;
	localparam int FW         = cwct_pkg::FW;
	localparam int QW         = cwct_pkg::QW;
	localparam int DIV_LAT    = cwct_pkg::DIV_LAT;

	function automatic logic [31:0] dv_sat(input logic neg, input logic ovf,
			input logic [QW-1:0] m);
		logic [31:0] r;
		if (neg) begin
			r = ovf ? 32'h8000_0000 : 32'd0 - {1'b0, m};
		end else begin
			r = ovf ? 32'h7FFF_FFFF : {1'b0, m};
		end
		return r;
	endfunction

	logic signed [31:0] center_x_q;
	logic signed [31:0] center_y_q;
	logic [30:0]        arena_radius_q;
	logic [15:0]        eps_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q     <= '0;
			center_y_q     <= '0;
			arena_radius_q <= '0;
			eps_q          <= 16'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cwct_pkg::REG_CENTER_X:     center_x_q     <= cfg_data;
				cwct_pkg::REG_CENTER_Y:     center_y_q     <= cfg_data;
				cwct_pkg::REG_ARENA_RADIUS: arena_radius_q <= cfg_data[30:0];
				cwct_pkg::REG_EPSILON:      eps_q          <= cfg_data[15:0];
			endcase
		end
	end

	// Stage 1: offsets from the arena center and the search limit.
	logic               vld_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [31:0] rr_s1, vx_s1, vy_s1;
	logic [16:0]        tnow_s1;
	logic signed [17:0] last_s1;
	logic signed [18:0] lim_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= {pos_x[31], pos_x} - {center_x_q[31], center_x_q};
		dy_s1   <= {pos_y[31], pos_y} - {center_y_q[31], center_y_q};
		rr_s1   <= $signed({1'b0, arena_radius_q}) - $signed({1'b0, disc_radius});
		vx_s1   <= vel_x;
		vy_s1   <= vel_y;
		tnow_s1 <= time_now;
		last_s1 <= last_wall_time;
		lim_s1  <= 19'sd65536 - $signed({2'b0, time_now}) + $signed({3'b0, eps_q});
	end

	// Stage 2: products.
	logic               vld_s2, rpos_s2;
	logic signed [63:0] vx2_s2, vy2_s2, rr2_s2;
	logic signed [64:0] dxvx_s2, dyvy_s2;
	logic signed [65:0] dx2_s2, dy2_s2;
	logic signed [18:0] lim_s2;
	cwct_pkg::carry_t   cy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		vx2_s2  <= vx_s1 * vx_s1;
		vy2_s2  <= vy_s1 * vy_s1;
		rr2_s2  <= rr_s1 * rr_s1;
		dxvx_s2 <= dx_s1 * vx_s1;
		dyvy_s2 <= dy_s1 * vy_s1;
		dx2_s2  <= dx_s1 * dx_s1;
		dy2_s2  <= dy_s1 * dy_s1;
		rpos_s2 <= rr_s1 > 32'sd0;
		lim_s2  <= lim_s1;
		cy_s2   <= '{dx: dx_s1, dy: dy_s1, vx: vx_s1, vy: vy_s1, tnow: tnow_s1,
			last: last_s1};
	end

	// Stage 3: quadratic coefficients and the choice of path.
	logic [63:0]        a_c, thr_c;
	logic signed [65:0] h_c;
	logic signed [67:0] c_c, ce_c;
	logic               srch_c, tz_c;
	logic               vld_s3;
	cwct_pkg::srch_t    pay_s3;

	always_comb begin
		a_c    = vx2_s2 + vy2_s2;
		h_c    = {dxvx_s2[64], dxvx_s2} + {dyvy_s2[64], dyvy_s2};
		c_c    = 68'(dx2_s2) + 68'(dy2_s2) - 68'(rr2_s2);
		ce_c   = c_c + $signed({36'b0, eps_q, 16'b0});
		thr_c  = (eps_q == 16'd0) ? 64'd1 : {32'b0, eps_q, 16'b0};
		srch_c = 1'b0;
		tz_c   = 1'b0;
		// A disc that does not fit hits at once, as does one that already touches the wall and is not too slow.
		priority if (!rpos_s2) begin
			tz_c = 1'b1;
		end else if (a_c < thr_c) begin
			tz_c = 1'b0;
		end else if (!ce_c[67]) begin
			tz_c = 1'b1;
		end else if (lim_s2 > 19'sd0) begin
			srch_c = 1'b1;
		end else begin
			srch_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		pay_s3.vld    <= 1'b0;
		pay_s3.srch   <= srch_c;
		pay_s3.t_zero <= tz_c;
		pay_s3.lim    <= lim_s2;
		pay_s3.a      <= a_c;
		pay_s3.h      <= h_c;
		pay_s3.f      <= FW'(c_c) <<< 32;
		pay_s3.g      <= '0;
		pay_s3.t0     <= '0;
		pay_s3.cy     <= cy_s2;
	end

	cwct_pkg::srch_t srch_w [0:SRCH_STEPS];

	always_comb begin
		srch_w[0]     = pay_s3;
		srch_w[0].vld = vld_s3;
	end

	for (genvar i = 0; i < SRCH_STEPS; i++) begin : g_srch
		cwct_srch_stage #(
			.BIT (SRCH_STEPS - 1 - i)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.d      (srch_w[i]),
			.q      (srch_w[i+1])
		);
	end

	// Stage 21: hit time and the window test.
	cwct_pkg::srch_t    so;
	logic [17:0]        t_c;
	logic [18:0]        tf_c;
	logic signed [19:0] lo_c;
	logic               ok_c, hit_c;

	always_comb begin
		so   = srch_w[SRCH_STEPS];
		t_c  = so.srch ? 18'(so.t0) + 18'd1 : 18'd0;
		ok_c = so.t_zero || (so.srch && ($signed({2'b0, so.t0}) < so.lim));
		tf_c = 19'(so.cy.tnow) + 19'(t_c);
		lo_c = 20'(so.cy.last) + $signed({4'b0, eps_q});
		hit_c = ok_c && ($signed({1'b0, tf_c}) > lo_c)
			&& (tf_c <= 19'd65536 + {3'b0, eps_q});
	end

	logic             vld_s21, hit_s21;
	logic [17:0]      tf_s21, t_s21;
	cwct_pkg::carry_t cy_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s21 <= 1'b0;
		end else begin
			vld_s21 <= so.vld;
		end
	end

	always_ff @(posedge clk) begin
		hit_s21 <= hit_c;
		tf_s21  <= tf_c[17:0];
		t_s21   <= t_c;
		cy_s21  <= so.cy;
	end

	// Stage 22: distance traveled up to the hit.
	logic               vld_s22, hit_s22;
	logic [17:0]        tf_s22;
	logic signed [50:0] vxt_s22, vyt_s22;
	cwct_pkg::carry_t   cy_s22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s22 <= 1'b0;
		end else begin
			vld_s22 <= vld_s21;
		end
	end

	always_ff @(posedge clk) begin
		vxt_s22 <= cy_s21.vx * $signed({1'b0, t_s21});
		vyt_s22 <= cy_s21.vy * $signed({1'b0, t_s21});
		hit_s22 <= hit_s21;
		tf_s22  <= tf_s21;
		cy_s22  <= cy_s21;
	end

	// Stage 23: wall normal at the hit, as sign and magnitude.
	logic signed [35:0] px_c, py_c;
	logic               vld_s23, hit_s23, sx_s23, sy_s23;
	logic [35:0]        mx_s23, my_s23;
	logic [17:0]        tf_s23;
	logic signed [31:0] vx_s23, vy_s23;

	always_comb begin
		px_c = 36'(cy_s22.dx) + 36'(vxt_s22 >>> 16);
		py_c = 36'(cy_s22.dy) + 36'(vyt_s22 >>> 16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s23 <= 1'b0;
		end else begin
			vld_s23 <= vld_s22;
		end
	end

	always_ff @(posedge clk) begin
		sx_s23  <= px_c[35];
		sy_s23  <= py_c[35];
		mx_s23  <= px_c[35] ? 36'd0 - px_c : px_c;
		my_s23  <= py_c[35] ? 36'd0 - py_c : py_c;
		hit_s23 <= hit_s22;
		tf_s23  <= tf_s22;
		vx_s23  <= cy_s22.vx;
		vy_s23  <= cy_s22.vy;
	end

	// Stage 24: scale the normal down to 15-bit magnitudes.
	logic [35:0]        or_c;
	logic [5:0]         bl_c, sh_c;
	logic               vld_s24, hit_s24, sx_s24, sy_s24;
	logic [14:0]        pxm_s24, pym_s24;
	logic [17:0]        tf_s24;
	logic signed [31:0] vx_s24, vy_s24;

	always_comb begin
		or_c = mx_s23 | my_s23;
		bl_c = '0;
		for (int i = 0; i < 36; i++) begin
			if (or_c[i]) begin
				bl_c = 6'(i + 1);
			end
		end
		sh_c = (bl_c > 6'd15) ? bl_c - 6'd15 : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s24 <= 1'b0;
		end else begin
			vld_s24 <= vld_s23;
		end
	end

	always_ff @(posedge clk) begin
		pxm_s24 <= 15'(mx_s23 >> sh_c);
		pym_s24 <= 15'(my_s23 >> sh_c);
		sx_s24  <= sx_s23;
		sy_s24  <= sy_s23;
		hit_s24 <= hit_s23;
		tf_s24  <= tf_s23;
		vx_s24  <= vx_s23;
		vy_s24  <= vy_s23;
	end

	// Stage 25: normal length squared and the velocity's projection.
	logic signed [15:0] px16_c, py16_c;
	logic signed [47:0] kx_c, ky_c;
	logic               vld_s25, hit_s25, nx_s25, ny_s25;
	logic [14:0]        pxm_s25, pym_s25;
	logic [31:0]        q_s25;
	logic signed [47:0] k_s25;
	logic [17:0]        tf_s25;

	always_comb begin
		px16_c = sx_s24 ? -$signed({1'b0, pxm_s24}) : $signed({1'b0, pxm_s24});
		py16_c = sy_s24 ? -$signed({1'b0, pym_s24}) : $signed({1'b0, pym_s24});
		kx_c   = px16_c * vx_s24;
		ky_c   = py16_c * vy_s24;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s25 <= 1'b0;
		end else begin
			vld_s25 <= vld_s24;
		end
	end

	always_ff @(posedge clk) begin
		q_s25   <= 32'(pxm_s24) * 32'(pxm_s24) + 32'(pym_s24) * 32'(pym_s24);
		k_s25   <= kx_c + ky_c;
		pxm_s25 <= pxm_s24;
		pym_s25 <= pym_s24;
		nx_s25  <= sx_s24;
		ny_s25  <= sy_s24;
		hit_s25 <= hit_s24;
		tf_s25  <= tf_s24;
	end

	// Stage 26: dividends 2*|k|*|P| and the sign of each change.
	logic [47:0]  km_c;
	logic         kn_c;
	logic         vld_s26;
	logic [63:0]  nx_s26, ny_s26;
	logic [31:0]  q_s26;
	cwct_pkg::sb_t sb_s26;

	always_comb begin
		kn_c = k_s25[47];
		km_c = kn_c ? 48'd0 - k_s25 : k_s25;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s26 <= 1'b0;
		end else begin
			vld_s26 <= vld_s25;
		end
	end

	always_ff @(posedge clk) begin
		nx_s26     <= 64'({km_c[46:0], 1'b0}) * 64'(pxm_s25);
		ny_s26     <= 64'({km_c[46:0], 1'b0}) * 64'(pym_s25);
		q_s26      <= q_s25;
		sb_s26.hit <= hit_s25;
		sb_s26.tf  <= tf_s25;
		sb_s26.ngx <= (k_s25 != 48'sd0) && (pxm_s25 != 15'd0) && (kn_c == nx_s25);
		sb_s26.ngy <= (k_s25 != 48'sd0) && (pym_s25 != 15'd0) && (kn_c == ny_s25);
		sb_s26.qz  <= q_s25 == 32'd0;
	end

	logic          ovfx, ovfy;
	logic [QW-1:0] quox, quoy;

	cwct_div u_div_x (
		.clk (clk),
		.num (nx_s26),
		.den (q_s26),
		.ovf (ovfx),
		.quo (quox)
	);

	cwct_div u_div_y (
		.clk (clk),
		.num (ny_s26),
		.den (q_s26),
		.ovf (ovfy),
		.quo (quoy)
	);

	// Side data travels alongside the dividers.
	logic          vld_d [0:DIV_LAT-1];
	cwct_pkg::sb_t sb_d  [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_d[i] <= 1'b0;
			end
		end else begin
			vld_d[0] <= vld_s26;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_d[i] <= vld_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		sb_d[0] <= sb_s26;
		for (int i = 1; i < DIV_LAT; i++) begin
			sb_d[i] <= sb_d[i-1];
		end
	end

	cwct_pkg::sb_t sbo;
	logic          dv_ok;

	always_comb begin
		sbo   = sb_d[DIV_LAT-1];
		dv_ok = sbo.hit && !sbo.qz;
	end

	logic               result_valid_q, hit_q;
	logic [17:0]        hit_time_q;
	logic signed [31:0] dv_x_q, dv_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= vld_d[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		hit_q      <= sbo.hit;
		hit_time_q <= sbo.hit ? sbo.tf : 18'd0;
		dv_x_q     <= dv_ok ? dv_sat(sbo.ngx, ovfx, quox) : 32'd0;
		dv_y_q     <= dv_ok ? dv_sat(sbo.ngy, ovfy, quoy) : 32'd0;
	end

	assign result_valid = result_valid_q;
	assign hit          = hit_q;
	assign hit_time     = hit_time_q;
	assign dv_x         = dv_x_q;
	assign dv_y         = dv_y_q;

endmodule

@@ sim/tb_circular_wall_collision_time_unit.sv @@
module tb_circular_wall_collision_time_unit;

	localparam int LATENCY = 59;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic               hit;
		logic [17:0]        tf;
		logic signed [31:0] dvx;
		logic signed [31:0] dvy;
	} wall_hit_t;

	class wall_hit_ledger;
		wall_hit_t pending[$];
		longint cen_x, cen_y, arena_r, eps;
		int mismatches;

		function new();
			cen_x = 0; cen_y = 0; arena_r = 0; eps = 1; mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				cwct_pkg::REG_CENTER_X:     cen_x = longint'($signed(val));
				cwct_pkg::REG_CENTER_Y:     cen_y = longint'($signed(val));
				cwct_pkg::REG_ARENA_RADIUS: arena_r = longint'(val[30:0]);
				cwct_pkg::REG_EPSILON:      eps = longint'(val[15:0]);
			endcase
		endfunction

		// Sign of a*T^2 + 2^17*h*T + 2^32*c, i.e. whether the edge reached the wall.
		function bit wall_reached(logic signed [127:0] aw, logic signed [127:0] h,
				logic signed [127:0] c, longint t);
			logic signed [127:0] tw, f;
			tw = t;
			f = aw * tw * tw + ((h * tw) <<< 17) + (c <<< 32);
			return f >= 0;
		endfunction

		function logic [31:0] reflect(longint k, longint r, longint unsigned q);
			longint unsigned m, mk, mr;
			mk = k < 0 ? -k : k;
			mr = r < 0 ? -r : r;
			m = (2 * mk * mr) / q;
			if (k != 0 && r != 0 && ((k < 0) == (r < 0)))
				return m >= 64'h8000_0000 ? 32'h8000_0000 : 32'(-m);
			return m > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(m);
		endfunction

		function void note(logic signed [31:0] px0, logic signed [31:0] py0,
				logic signed [31:0] vx0, logic signed [31:0] vy0, logic [30:0] dr,
				logic [16:0] tn, logic signed [17:0] lw);
			wall_hit_t e;
			longint dx, dy, vx, vy, rr, tnow, last, tt, tf, lim, lo, hi, mid, px, py, k;
			longint unsigned a, thr, mvx, mvy, mpx, mpy, q;
			logic signed [127:0] aw, h, c, w1, w2;
			int s;
			e = '{1'b0, 18'd0, 32'sd0, 32'sd0};
			dx = longint'(px0) - cen_x; dy = longint'(py0) - cen_y;
			vx = vx0; vy = vy0; tnow = tn; last = lw;
			rr = arena_r - longint'(dr);
			tt = 0;
			if (rr > 0) begin
				mvx = vx < 0 ? -vx : vx;
				mvy = vy < 0 ? -vy : vy;
				a = mvx * mvx + mvy * mvy;
				thr = eps << 16;
				if (thr == 0) thr = 1;
				if (a < thr) begin
					pending = {pending, e};
					return;
				end
				aw = {64'd0, a};
				w1 = dx; w2 = dy;
				h = w1 * vx + w2 * vy;
				c = w1 * w1 + w2 * w2;
				w1 = rr;
				c = c - w1 * w1;
				if (c + (eps << 16) < 0) begin
					lim = 65536 - tnow + eps;
					if (lim < 1 || !wall_reached(aw, h, c, lim)) begin
						pending = {pending, e};
						return;
					end
					lo = 1; hi = lim;
					while (lo < hi) begin
						mid = lo + (hi - lo) / 2;
						if (wall_reached(aw, h, c, mid)) hi = mid; else lo = mid + 1;
					end
					tt = lo;
				end
			end
			tf = tnow + tt;
			if (tf <= last + eps || tf > 65536 + eps) begin
				pending = {pending, e};
				return;
			end
			e.hit = 1'b1;
			e.tf = tf[17:0];
			px = dx + ((vx * tt) >>> 16);
			py = dy + ((vy * tt) >>> 16);
			mpx = px < 0 ? -px : px;
			mpy = py < 0 ? -py : py;
			s = 0;
			while ((mpx >> s) > 32767 || (mpy >> s) > 32767) s++;
			px = px < 0 ? -longint'(mpx >> s) : longint'(mpx >> s);
			py = py < 0 ? -longint'(mpy >> s) : longint'(mpy >> s);
			q = px * px + py * py;
			if (q != 0) begin
				k = px * vx + py * vy;
				e.dvx = reflect(k, px, q);
				e.dvy = reflect(k, py, q);
			end
			pending = {pending, e};
		endfunction

		function void check(logic h, logic [17:0] tf, logic [31:0] dvx, logic [31:0] dvy);
			wall_hit_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat: hit=%0b", h);
				return;
			end
			e = pending.pop_front();
			if (h !== e.hit || tf !== e.tf || dvx !== e.dvx || dvy !== e.dvy) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp hit=%0b t=%0d dv=(%0d,%0d) got hit=%0b t=%0d dv=(%0d,%0d)",
						e.hit, e.tf, e.dvx, e.dvy, h, tf, $signed(dvx), $signed(dvy));
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy;
	logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
	logic [30:0] disc_radius;
	logic [16:0] time_now;
	logic signed [17:0] last_wall_time;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic result_valid, hit;
	logic [17:0] hit_time;
	logic signed [31:0] dv_x, dv_y;

	wall_hit_ledger ledger = new();
	int stall_cycles = 0;

	circular_wall_collision_time_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (start && !busy)
			ledger.note(pos_x, pos_y, vel_x, vel_y, disc_radius, time_now, last_wall_time);
		if (result_valid)
			ledger.check(hit, hit_time, dv_x, dv_y);
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_circular_wall_collision_time_unit: FAIL");
			$finish;
		end
	end

	function automatic longint rnd_s(longint lim);
		longint u;
		u = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF;
		return (u % (2 * lim + 1)) - lim;
	endfunction

	function automatic logic [31:0] sat32(longint v);
		if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'h8000_0000;
		return 32'(v);
	endfunction

	task automatic send_disc(logic [31:0] px, logic [31:0] py, logic [31:0] vx,
			logic [31:0] vy, logic [30:0] dr, logic [16:0] tn, logic [17:0] lw);
		int r;
		start <= 1'b1;
		pos_x <= px; pos_y <= py; vel_x <= vx; vel_y <= vy;
		disc_radius <= dr; time_now <= tn; last_wall_time <= lw;
		@(posedge clk);
		while (busy) @(posedge clk);
		r = $urandom_range(0, 99);
		if (r >= 70) begin
			start <= 1'b0;
			repeat (r >= 95 ? $urandom_range(10, 40) : $urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		ledger.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_disc();
		longint r, lim;
		logic [16:0] tn;
		if ($urandom_range(0, 99) < 15) begin
			send_disc($urandom, $urandom, $urandom, $urandom, 31'($urandom),
				17'($urandom), 18'($urandom));
			return;
		end
		r = ledger.arena_r > 0 ? ledger.arena_r : 64'd100 << 16;
		lim = r / 2;
		tn = $urandom_range(0, 99) < 90 ? 17'($urandom_range(0, 65536)) : 17'($urandom);
		send_disc(sat32(ledger.cen_x + rnd_s(lim)) , sat32(ledger.cen_y + rnd_s(lim)),
			sat32(rnd_s(2 * r)), sat32(rnd_s(2 * r)), 31'(rnd_s(r / 4) & 64'h7FFF_FFFF),
			tn, $urandom_range(0, 9) < 8 ? 18'(longint'(tn) - $urandom_range(1, 70000))
				: 18'($urandom));
	endtask

	initial begin
		logic [31:0] setting[5][4];
		start = 1'b0; cfg_valid = 1'b0; cfg_index = cwct_pkg::REG_CENTER_X; cfg_data = '0;
		pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0; disc_radius = '0;
		time_now = '0; last_wall_time = '0;
		setting[0] = '{32'h0, 32'h0, 32'd100 << 16, 32'd1};
		setting[1] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0};
		setting[2] = '{32'd5 << 16, -(32'd7 << 16), 32'd1 << 16, 32'd65535};
		setting[3] = '{-(32'd20000 << 16), 32'd1234 << 16, 32'd3000 << 16, 32'd64};
		setting[4] = '{32'h0, 32'h0, 32'd1, 32'd0};
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset values: zero arena, every disc is too large.
		repeat (240) random_disc();
		drain();

		write_reg(cwct_pkg::REG_CENTER_X, 32'd3 << 16);
		write_reg(cwct_pkg::REG_CENTER_Y, -(32'd2 << 16));
		write_reg(cwct_pkg::REG_ARENA_RADIUS, 32'd100 << 16);
		write_reg(cwct_pkg::REG_EPSILON, 32'd16);
		send_disc(32'd3 << 16, -(32'd2 << 16), 0, 0, 31'd1 << 16, 17'd0, -18'sd1);
		send_disc(32'd3 << 16, -(32'd2 << 16), 32'd200 << 16, 0, 31'd1 << 16, 17'd0, -18'sd1);
		send_disc(32'd3 << 16, -(32'd2 << 16), 0, -(32'd150 << 16), 31'd5 << 16, 17'd1000,
			18'd0);
		send_disc(32'd102 << 16, -(32'd2 << 16), 32'd1 << 16, 0, 31'd1 << 16, 17'd10, 18'd0);
		send_disc(32'd3 << 16, -(32'd2 << 16), 32'd1 << 16, 0, 31'd200 << 16, 17'd5, 18'd0);
		send_disc(32'd3 << 16, -(32'd2 << 16), 32'd5 << 16, 32'd7 << 16, 31'h7FFF_FFFF,
			17'd65536, 18'd65535);
		send_disc(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0,
			17'd0, 18'h20000);
		send_disc(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0,
			17'h1FFFF, 18'h1FFFF);
		send_disc(32'd50 << 16, 32'd10 << 16, 32'd300 << 16, -(32'd90 << 16), 31'd3 << 16,
			17'd65536, -18'sd65536);
		send_disc(32'd3 << 16, -(32'd2 << 16), 32'd60 << 16, 32'd60 << 16, 31'd1 << 16,
			17'd40000, 18'd39000);
		send_disc(32'd3 << 16, -(32'd2 << 16), 32'd60 << 16, 32'd60 << 16, 31'd1 << 16,
			17'd70000, 18'd0);
		send_disc(-(32'd40 << 16), 32'd30 << 16, -(32'd500 << 16), 32'd20 << 16, 31'd0,
			17'd32768, 18'd65536);
		send_disc(32'd3 << 16, -(32'd2 << 16), 32'd2, 32'd1, 31'd1 << 16, 17'd0, -18'sd100);
		drain();
		write_reg(cwct_pkg::REG_EPSILON, 32'd0);
		send_disc(32'd3 << 16, -(32'd2 << 16), 0, 0, 31'd1 << 16, 17'd0, -18'sd1);
		send_disc(32'd3 << 16, -(32'd2 << 16), 0, 32'd1, 31'd1 << 16, 17'd0, -18'sd1);
		send_disc(32'd3 << 16, -(32'd2 << 16), 32'd120 << 16, 0, 31'd1 << 16, 17'd0, -18'sd1);
		drain();

		foreach (setting[i]) begin
			write_reg(cwct_pkg::REG_CENTER_X, setting[i][0]);
			write_reg(cwct_pkg::REG_CENTER_Y, setting[i][1]);
			write_reg(cwct_pkg::REG_ARENA_RADIUS, setting[i][2]);
			write_reg(cwct_pkg::REG_EPSILON, setting[i][3]);
			repeat (120) random_disc();
			// Let the pipeline run dry once with the sender holding off.
			drain();
			repeat (120) random_disc();
			drain();
		end

		if (ledger.mismatches == 0 && ledger.pending.size() == 0)
			$display("tb_circular_wall_collision_time_unit: PASS");
		else
			$display("tb_circular_wall_collision_time_unit: FAIL");
		$finish;
	end

endmodule
